[rtl/wqf_pkg.sv]
// Shared types and constants for the waypoint queue follower.
// Holds operation and status codes, register indexes, sequencer states and the
// CORDIC arctangent table. No dependencies.
package wqf_pkg;

   typedef enum logic [1:0] {
      OP_CLEAR = 2'd0,
      OP_PUSH  = 2'd1,
      OP_POSE  = 2'd2
   } op_type;

   typedef enum logic [2:0] {
      ST_ACCEPTED = 3'd0,
      ST_DROPPED  = 3'd1,
      ST_COMMAND  = 3'd2,
      ST_FINISHED = 3'd3,
      ST_IDLE     = 3'd4
   } status_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_READ,
      S_ABS,
      S_SQX,
      S_SQY,
      S_SQR,
      S_CMP,
      S_CORDIC,
      S_GAIN,
      S_SAT,
      S_EMIT
   } state_type;

   typedef struct packed {
      logic        done;
      logic [15:0] bearing;
   } cordic_result_type;

   localparam logic [1:0] CSR_REACH_RADIUS = 2'd0;
   localparam logic [1:0] CSR_TURN_GAIN    = 2'd1;
   localparam logic [1:0] CSR_TURN_LIMIT   = 2'd2;
   localparam logic [1:0] CSR_CRUISE_SPEED = 2'd3;

   localparam int CSR_WIDTH = 20;
   localparam int ATAN_ENTRIES = 24;
   localparam int CORDIC_WIDTH = 36;
   localparam int MUL_WIDTH = 21;

   localparam logic [19:0] REACH_RADIUS_RESET = 20'd6554;
   localparam logic [15:0] TURN_GAIN_RESET    = 16'd2048;
   localparam logic [14:0] TURN_LIMIT_RESET   = 15'd2086;
   localparam logic [15:0] CRUISE_SPEED_RESET = 16'd6554;

   // arctan(2^-i) in units of 2^-32 turn
   function automatic logic [31:0] atan_turn(input logic [4:0] i);
      logic [31:0] a;
      case (i)
         5'd0:  a = 32'd536870912;
         5'd1:  a = 32'd316933406;
         5'd2:  a = 32'd167458907;
         5'd3:  a = 32'd85004756;
         5'd4:  a = 32'd42667331;
         5'd5:  a = 32'd21354465;
         5'd6:  a = 32'd10679838;
         5'd7:  a = 32'd5340245;
         5'd8:  a = 32'd2670163;
         5'd9:  a = 32'd1335087;
         5'd10: a = 32'd667544;
         5'd11: a = 32'd333772;
         5'd12: a = 32'd166886;
         5'd13: a = 32'd83443;
         5'd14: a = 32'd41722;
         5'd15: a = 32'd20861;
         5'd16: a = 32'd10430;
         5'd17: a = 32'd5215;
         5'd18: a = 32'd2608;
         5'd19: a = 32'd1304;
         5'd20: a = 32'd652;
         5'd21: a = 32'd326;
         5'd22: a = 32'd163;
         5'd23: a = 32'd81;
         default: a = 32'd0;
      endcase
      return a;
   endfunction

endpackage

[rtl/waypoint_queue_follower_unit.sv]
// Waypoint queue follower: waypoint FIFO in RAM, distance check on a shared multiplier,
// iterative CORDIC bearing and a proportional heading command. Depends on wqf_pkg,
// wqf_ram and wqf_cordic.
//
// One item at a time. Clear, push and unused codes go straight to the result. A pose
// step with waypoints queued reads the head waypoint from RAM, makes three passes of the
// single 21x21 multiplier (squared x and y distance, squared reach radius), runs the
// CORDIC vectoring loop, makes one more multiplier pass for the gain and then saturates;
// reaching the last waypoint ends the step before the CORDIC. req_stall is high from accept
// until the result is loaded into the output register; the next item is taken while
// that result still waits. The queue RAM has no reset; head pointer and count do.
module waypoint_queue_follower_unit #(
   parameter int PATH_DEPTH   = 64,
   parameter int CORDIC_STEPS = 16
) (
   input  logic                              clock,
   input  logic                              reset,

   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic [1:0]                        req_operation,
   input  logic signed [31:0]                req_waypoint_x,
   input  logic signed [31:0]                req_waypoint_y,
   input  logic signed [31:0]                req_pose_x,
   input  logic signed [31:0]                req_pose_y,
   input  logic signed [15:0]                req_heading,

   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output wqf_pkg::status_type               rsp_status,
   output logic signed [15:0]                rsp_angular_rate,
   output logic [15:0]                       rsp_forward_speed,
   output logic [$clog2(PATH_DEPTH+1)-1:0]   rsp_waypoints_left,

   input  logic                              csr_write,
   input  logic [1:0]                        csr_index,
   input  logic [wqf_pkg::CSR_WIDTH-1:0]     csr_wdata
);
   import wqf_pkg::*;

   localparam int PTR_W = $clog2(PATH_DEPTH);
   localparam int CNT_W = $clog2(PATH_DEPTH + 1);
   localparam int PRD_W = 2 * MUL_WIDTH;

   state_type state_ff, state_in;

   logic [19:0] reach_ff;
   logic [15:0] gain_ff;
   logic [14:0] limit_ff;
   logic [15:0] cruise_ff;

   logic [PTR_W-1:0] head_ff, head_in;
   logic [CNT_W-1:0] count_ff, count_in;

   logic signed [31:0] pose_x_ff, pose_y_ff;
   logic signed [15:0] heading_ff;
   logic signed [32:0] dx_ff, dx_in, dy_ff, dy_in;
   logic [32:0]        ax_ff, ax_in, ay_ff, ay_in;
   logic               near_ff, near_in;
   logic [40:0]        acc_ff, acc_in;
   logic signed [PRD_W-1:0] prod_ff, prod_in;
   logic signed [15:0] err_ff, err_in;

   status_type         res_status_ff, res_status_in;
   logic signed [15:0] res_rate_ff, res_rate_in;
   logic [15:0]        res_speed_ff, res_speed_in;

   logic               rsp_valid_ff, rsp_valid_in;
   status_type         rsp_status_ff, rsp_status_in;
   logic signed [15:0] rsp_rate_ff, rsp_rate_in;
   logic [15:0]        rsp_speed_ff, rsp_speed_in;
   logic [CNT_W-1:0]   rsp_left_ff, rsp_left_in;

   logic               accept;
   logic               wr_en;
   logic [PTR_W-1:0]   wr_addr;
   logic [PTR_W:0]     slot_sum;
   logic [63:0]        rd_data;
   logic signed [31:0] rd_x, rd_y;

   logic                    mul_load;
   logic signed [MUL_WIDTH-1:0] mul_a, mul_b;
   logic signed [PRD_W-1:0] rnd_sum, cmd_full;
   logic signed [15:0]      cmd_sat;
   logic [16:0]             cmd_mag;

   logic              cordic_start;
   cordic_result_type cordic_res;

   assign accept = req_valid && !req_stall;
   assign req_stall = (state_ff != S_IDLE);
   assign rd_x = rd_data[31:0];
   assign rd_y = rd_data[63:32];

   always_comb begin
      slot_sum = {1'b0, head_ff} + (PTR_W+1)'(count_ff);
      if (slot_sum >= (PTR_W+1)'(PATH_DEPTH)) begin
         slot_sum = slot_sum - (PTR_W+1)'(PATH_DEPTH);
      end
      wr_addr = slot_sum[PTR_W-1:0];
   end

   assign wr_en = accept && (op_type'(req_operation) == OP_PUSH) &&
                  (count_ff != CNT_W'(PATH_DEPTH));

   wqf_ram #(
      .WIDTH(64),
      .DEPTH(PATH_DEPTH)
   ) u_queue (
      .clock  (clock),
      .wr_en  (wr_en),
      .wr_addr(wr_addr),
      .wr_data({req_waypoint_y, req_waypoint_x}),
      .rd_addr(head_ff),
      .rd_data(rd_data)
   );

   wqf_cordic #(
      .CORDIC_STEPS(CORDIC_STEPS)
   ) u_cordic (
      .clock (clock),
      .reset (reset),
      .start (cordic_start),
      .dx    (dx_ff),
      .dy    (dy_ff),
      .result(cordic_res)
   );

   // shared multiplier operand select
   always_comb begin
      mul_a = '0;
      mul_b = '0;
      mul_load = 1'b0;
      unique case (state_ff)
         S_SQX: begin
            mul_a = $signed({1'b0, ax_ff[19:0]});
            mul_b = $signed({1'b0, ax_ff[19:0]});
            mul_load = 1'b1;
         end
         S_SQY: begin
            mul_a = $signed({1'b0, ay_ff[19:0]});
            mul_b = $signed({1'b0, ay_ff[19:0]});
            mul_load = 1'b1;
         end
         S_SQR: begin
            mul_a = $signed({1'b0, reach_ff});
            mul_b = $signed({1'b0, reach_ff});
            mul_load = 1'b1;
         end
         S_GAIN: begin
            mul_a = {{(MUL_WIDTH-16){err_ff[15]}}, err_ff};
            mul_b = $signed({{(MUL_WIDTH-16){1'b0}}, gain_ff});
            mul_load = 1'b1;
         end
         default: begin
            mul_load = 1'b0;
         end
      endcase
      prod_in = mul_load ? mul_a * mul_b : prod_ff;
   end

   always_comb begin
      rnd_sum = prod_ff + PRD_W'(2048);
      cmd_full = rnd_sum >>> 12;
      if (cmd_full > PRD_W'(32767)) begin
         cmd_sat = 16'sh7FFF;
      end else if (cmd_full < -(PRD_W'(32768))) begin
         cmd_sat = -16'sh8000;
      end else begin
         cmd_sat = cmd_full[15:0];
      end
      cmd_mag = cmd_sat[15] ? 17'(-{cmd_sat[15], cmd_sat}) : {1'b0, cmd_sat};
   end

   always_comb begin
      state_in = state_ff;
      head_in = head_ff;
      count_in = count_ff;
      dx_in = dx_ff;
      dy_in = dy_ff;
      ax_in = ax_ff;
      ay_in = ay_ff;
      near_in = near_ff;
      acc_in = acc_ff;
      err_in = err_ff;
      res_status_in = res_status_ff;
      res_rate_in = res_rate_ff;
      res_speed_in = res_speed_ff;
      cordic_start = 1'b0;

      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_status_in = rsp_status_ff;
      rsp_rate_in = rsp_rate_ff;
      rsp_speed_in = rsp_speed_ff;
      rsp_left_in = rsp_left_ff;

      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               res_status_in = ST_ACCEPTED;
               res_rate_in = '0;
               res_speed_in = '0;
               state_in = S_EMIT;
               case (op_type'(req_operation))
                  OP_CLEAR: begin
                     head_in = '0;
                     count_in = '0;
                  end
                  OP_PUSH: begin
                     if (count_ff == CNT_W'(PATH_DEPTH)) begin
                        res_status_in = ST_DROPPED;
                     end else begin
                        count_in = count_ff + 1'b1;
                     end
                  end
                  OP_POSE: begin
                     if (count_ff == '0) begin
                        res_status_in = ST_IDLE;
                     end else begin
                        state_in = S_READ;
                     end
                  end
                  default: begin
                     res_status_in = ST_ACCEPTED;
                  end
               endcase
            end
         end
         S_READ: begin
            dx_in = {rd_x[31], rd_x} - {pose_x_ff[31], pose_x_ff};
            dy_in = {rd_y[31], rd_y} - {pose_y_ff[31], pose_y_ff};
            state_in = S_ABS;
         end
         S_ABS: begin
            ax_in = dx_ff[32] ? 33'(-dx_ff) : 33'(dx_ff);
            ay_in = dy_ff[32] ? 33'(-dy_ff) : 33'(dy_ff);
            state_in = S_SQX;
         end
         S_SQX: begin
            near_in = (ax_ff[32:20] == '0) && (ay_ff[32:20] == '0);
            state_in = S_SQY;
         end
         S_SQY: begin
            acc_in = prod_ff[40:0];
            state_in = S_SQR;
         end
         S_SQR: begin
            acc_in = acc_ff + prod_ff[40:0];
            state_in = S_CMP;
         end
         S_CMP: begin
            if (near_ff && (acc_ff < prod_ff[40:0])) begin
               head_in = (head_ff == PTR_W'(PATH_DEPTH - 1)) ? '0 : head_ff + 1'b1;
               count_in = count_ff - 1'b1;
            end
            if (near_ff && (acc_ff < prod_ff[40:0]) && (count_ff == CNT_W'(1))) begin
               res_status_in = ST_FINISHED;
               state_in = S_EMIT;
            end else begin
               cordic_start = 1'b1;
               state_in = S_CORDIC;
            end
         end
         S_CORDIC: begin
            if (cordic_res.done) begin
               err_in = $signed(cordic_res.bearing - heading_ff);
               state_in = S_GAIN;
            end
         end
         S_GAIN: begin
            state_in = S_SAT;
         end
         S_SAT: begin
            res_status_in = ST_COMMAND;
            res_rate_in = cmd_sat;
            res_speed_in = (cmd_mag < {2'b00, limit_ff}) ? cruise_ff : '0;
            state_in = S_EMIT;
         end
         S_EMIT: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in = 1'b1;
               rsp_status_in = res_status_ff;
               rsp_rate_in = res_rate_ff;
               rsp_speed_in = res_speed_ff;
               rsp_left_in = count_ff;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         head_ff      <= '0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
         reach_ff     <= REACH_RADIUS_RESET;
         gain_ff      <= TURN_GAIN_RESET;
         limit_ff     <= TURN_LIMIT_RESET;
         cruise_ff    <= CRUISE_SPEED_RESET;
      end else begin
         state_ff     <= state_in;
         head_ff      <= head_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_write) begin
            unique case (csr_index)
               CSR_REACH_RADIUS: reach_ff  <= csr_wdata[19:0];
               CSR_TURN_GAIN:    gain_ff   <= csr_wdata[15:0];
               CSR_TURN_LIMIT:   limit_ff  <= csr_wdata[14:0];
               CSR_CRUISE_SPEED: cruise_ff <= csr_wdata[15:0];
               default:          reach_ff  <= reach_ff;
            endcase
         end
      end
      if (accept) begin
         pose_x_ff  <= req_pose_x;
         pose_y_ff  <= req_pose_y;
         heading_ff <= req_heading;
      end
      dx_ff         <= dx_in;
      dy_ff         <= dy_in;
      ax_ff         <= ax_in;
      ay_ff         <= ay_in;
      near_ff       <= near_in;
      acc_ff        <= acc_in;
      prod_ff       <= prod_in;
      err_ff        <= err_in;
      res_status_ff <= res_status_in;
      res_rate_ff   <= res_rate_in;
      res_speed_ff  <= res_speed_in;
      rsp_status_ff <= rsp_status_in;
      rsp_rate_ff   <= rsp_rate_in;
      rsp_speed_ff  <= rsp_speed_in;
      rsp_left_ff   <= rsp_left_in;
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_status         = rsp_status_ff;
   assign rsp_angular_rate   = rsp_rate_ff;
   assign rsp_forward_speed  = rsp_speed_ff;
   assign rsp_waypoints_left = rsp_left_ff;

endmodule

[rtl/wqf_ram.sv]
// Generic simple dual-port RAM: one write port, one read port with registered data.
// No dependencies.
module wqf_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

[rtl/wqf_cordic.sv]
// Iterative vectoring CORDIC: one add/subtract/shift step per cycle gives the bearing
// of (dx, dy) as a 16-bit binary angle. Depends on wqf_pkg.
module wqf_cordic #(
   parameter int CORDIC_STEPS = 16
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   input  logic signed [32:0]         dx,
   input  logic signed [32:0]         dy,
   output wqf_pkg::cordic_result_type result
);
   import wqf_pkg::*;

   localparam int STEP_W = $clog2(CORDIC_STEPS);

   logic signed [CORDIC_WIDTH-1:0] x_ff, x_in, y_ff, y_in;
   logic [31:0]       z_ff, z_in;
   logic [STEP_W-1:0] cnt_ff, cnt_in;
   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   logic              zero_ff, zero_in;

   logic signed [CORDIC_WIDTH-1:0] dx_ext, dy_ext, xs, ys;
   logic [31:0] atan_val;
   logic [31:0] z_round;

   always_comb begin
      dx_ext = {{(CORDIC_WIDTH-33){dx[32]}}, dx};
      dy_ext = {{(CORDIC_WIDTH-33){dy[32]}}, dy};
      xs = x_ff >>> cnt_ff;
      ys = y_ff >>> cnt_ff;
      atan_val = atan_turn(5'(cnt_ff));

      x_in = x_ff;
      y_in = y_ff;
      z_in = z_ff;
      cnt_in = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      zero_in = zero_ff;

      if (start) begin
         zero_in = (dx == 33'sd0) && (dy == 33'sd0);
         busy_in = 1'b1;
         cnt_in = '0;
         if (dx[32]) begin
            x_in = -dx_ext;
            y_in = -dy_ext;
            z_in = 32'h8000_0000;
         end else begin
            x_in = dx_ext;
            y_in = dy_ext;
            z_in = 32'd0;
         end
      end else if (busy_ff) begin
         if (!y_ff[CORDIC_WIDTH-1]) begin
            x_in = x_ff + ys;
            y_in = y_ff - xs;
            z_in = z_ff + atan_val;
         end else begin
            x_in = x_ff - ys;
            y_in = y_ff + xs;
            z_in = z_ff - atan_val;
         end
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == STEP_W'(CORDIC_STEPS - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      x_ff    <= x_in;
      y_ff    <= y_in;
      z_ff    <= z_in;
      zero_ff <= zero_in;
   end

   assign z_round = z_ff + 32'h0000_8000;
   assign result.done = done_ff;
   assign result.bearing = zero_ff ? 16'd0 : z_round[31:16];

endmodule
